### design/ptw_pkg.sv
// Package: shared widths, codes, state type and chain structs of the timing wheel.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int ID_W        = 4;
    localparam int MODE_W      = 2;
    localparam int PERIOD_W    = 16;
    localparam int PERIOD_MAX  = 65535;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DRAIN
    } t_state;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic            tick;
        logic            arm;
        logic            del;
        logic [ID_W-1:0] id;
    } t_cell_cmd;

    // Expiry token handed from cell to cell toward the output.
    typedef struct packed {
        logic            flag;
        logic [ID_W-1:0] id;
    } t_token;

endpackage

### design/ptw_ifs.sv
// Interfaces: request channel and expiry channel of the timing wheel.
`timescale 1ns / 1ps

interface ptw_in_if import ptw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;

    modport source (output valid, output mode, output task_id, output period, input ready);
    modport sink   (input valid, input mode, input task_id, input period, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] expired_id;
    logic            last;

    modport source (output valid, output expired_id, output last, input ready);
    modport sink   (input valid, input expired_id, input last, output ready);
endinterface

### design/ptw_div.sv
// Divider: splits a period into wheel passes and slot offset by reciprocal multiplication.
`timescale 1ns / 1ps

module ptw_div import ptw_pkg::*; #(
    parameter int SLOTS = 10,
    localparam int SW = $clog2(SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_dividend,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_quo,
    output logic [SW-1:0]       o_rem
);

    // The reciprocal of the wheel size is rounded up and scaled by one extra bit per
    // bit of the divisor, which makes the quotient exact for every dividend.
    localparam int SHIFT   = PERIOD_W + $clog2(SLOTS);
    localparam int RECIP_W = PERIOD_W + 1;
    localparam int PROD_W  = PERIOD_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic                r_stage;
    logic                r_done;
    logic [PERIOD_W-1:0] r_num;
    logic [PERIOD_W-1:0] r_quo;
    logic [SW-1:0]       r_rem;

    logic [PROD_W-1:0]   w_prod;
    logic [PERIOD_W-1:0] w_back;

    // First the quotient is registered from the product; then the remainder is
    // registered: what is left of the dividend after the whole passes come off.
    assign w_prod = PROD_W'(i_dividend) * PROD_W'(RECIP);
    assign w_back = r_num - PERIOD_W'(r_quo * PERIOD_W'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_quo <= PERIOD_W'(w_prod >> SHIFT);
        end
        if (r_stage) begin
            r_rem <= SW'(w_back);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### design/ptw_cell.sv
// Cell: one timer entry of the wheel and one stage of the expiry token chain.
`timescale 1ns / 1ps

module ptw_cell import ptw_pkg::*; #(
    parameter int SLOTS = 10,
    parameter int IDX   = 0,
    localparam int SW = $clog2(SLOTS),
    localparam int RW = $clog2(PERIOD_MAX / SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [SW-1:0] i_cursor,
    input  logic [SW-1:0] i_rem,
    input  logic [RW-1:0] i_quo,
    input  logic          i_shift,
    input  t_token        i_next,
    output t_token        o_tok
);

    // Only the first sixteen entries can be addressed by a task id.
    localparam bit MATCHABLE = (IDX < (1 << ID_W));

    logic            r_valid;
    logic [SW-1:0]   r_slot;
    logic [RW-1:0]   r_rounds;
    logic [SW-1:0]   r_rem;
    logic [RW-1:0]   r_quo;
    logic            r_flag;
    logic [ID_W-1:0] r_id;

    logic          w_match;
    logic          w_hit;
    logic          w_expire;
    logic [SW-1:0] w_arm_rem;
    logic [RW-1:0] w_arm_quo;
    logic [SW:0]   w_sum;
    logic [SW-1:0] w_slot;
    logic [RW-1:0] w_rounds;

    assign w_match  = MATCHABLE && (i_cmd.id == ID_W'(IDX));
    assign w_hit    = r_valid && (r_slot == i_cursor);
    assign w_expire = w_hit && (r_rounds == '0);

    // Arming: slot is offset plus cursor modulo the wheel size. A zero offset lands
    // on the cursor itself, which is one pass sooner, so one round comes off.
    assign w_arm_rem = i_cmd.arm ? i_rem : r_rem;
    assign w_arm_quo = i_cmd.arm ? i_quo : r_quo;
    assign w_sum     = {1'b0, w_arm_rem} + {1'b0, i_cursor};
    assign w_slot    = (w_sum >= (SW+1)'(SLOTS)) ? SW'(w_sum - (SW+1)'(SLOTS)) : w_sum[SW-1:0];
    assign w_rounds  = (w_arm_rem == '0) ? (w_arm_quo - 1'b1) : w_arm_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            if (i_cmd.arm && w_match) begin
                r_valid <= 1'b1;
            end else if (i_cmd.del && w_match) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.tick) begin
                r_flag <= w_expire;
            end else if (i_shift) begin
                r_flag <= i_next.flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arm && w_match) begin
            r_slot   <= w_slot;
            r_rounds <= w_rounds;
            r_rem    <= i_rem;
            r_quo    <= i_quo;
        end else if (i_cmd.tick && w_expire) begin
            r_slot   <= w_slot;
            r_rounds <= w_rounds;
        end else if (i_cmd.tick && w_hit) begin
            r_rounds <= r_rounds - 1'b1;
        end
        if (i_cmd.tick) begin
            r_id <= ID_W'(IDX);
        end else if (i_shift) begin
            r_id <= i_next.id;
        end
    end

    assign o_tok = {r_flag, r_id};

endmodule

### design/periodic_timing_wheel.sv
// Top level: periodic timing wheel built as a chain of timer cells.
`timescale 1ns / 1ps

// The block keeps TASKS periodic timers on a wheel of SLOTS slots.
// Requests arrive on i_req (mode, task_id, period). An add request arms or
// re-arms a task; its period is split into wheel passes and slot offset by a
// reciprocal multiplication in two registered steps, and no request is taken
// until the task is armed. A delete request holds up no later request. A tick
// request advances the cursor; in that cycle every cell checks its own slot in
// parallel, expires or counts down one pass, and loads an expiry token. The
// tokens then shift one cell per cycle toward cell 0 while the output is not
// stalled, and no request is taken until the last expiring cell's token, or
// the sixteenth expiry, has left the chain. The expiry of cell k passes through
// the cells below it to cell 0 and the output register before it reaches o_rsp.
// Expiries leave in table order, at most 16 per tick, the final marked by last.
// Each expiry sits in an output register; a stalled receiver halts the chain
// shift but the last expiry of a tick does not hold up the next request.
// Zero periods, task ids beyond the table and the unused mode code are
// accepted and ignored. Reset empties the table, puts the cursor at slot 0 and
// drops any expiry not yet taken; no clearing pass is needed.

module periodic_timing_wheel import ptw_pkg::*; #(
    parameter int SLOTS = 10,
    parameter int TASKS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptw_in_if.sink    i_req,
    ptw_out_if.source o_rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int RW = $clog2(PERIOD_MAX / SLOTS + 1);
    localparam bit ALL_IDS = (TASKS >= (1 << ID_W));

    t_state          r_state;
    t_state          n_state;
    logic [SW-1:0]   r_cursor;
    logic [CNT_W-1:0] r_cnt;
    logic [ID_W-1:0] r_arm_id;
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_last;

    logic            w_accept;
    logic            w_is_tick;
    logic            w_is_add;
    logic            w_is_del;
    logic            w_add_ok;
    logic [SW-1:0]   w_cursor_nxt;
    logic [SW-1:0]   w_cursor_bus;

    logic            w_in_ready;
    logic            w_div_start;
    logic            w_shift;
    logic            w_emit;
    logic            w_emit_last;
    logic            w_drain_done;
    t_cell_cmd       w_cmd;

    logic            w_div_done;
    logic [PERIOD_W-1:0] w_div_quo;
    logic [SW-1:0]   w_div_rem;

    t_token          w_tok [TASKS];
    logic [TASKS-1:0] w_flags;
    logic            w_any_flag;
    logic            w_rest_any;
    logic            w_can_out;

    // Request decode.
    always_comb begin
        w_is_tick = 1'b0;
        w_is_add  = 1'b0;
        w_is_del  = 1'b0;
        unique case (i_req.mode)
            MODE_TICK: w_is_tick = 1'b1;
            MODE_ADD:  w_is_add  = 1'b1;
            MODE_DEL:  w_is_del  = 1'b1;
            default:   ;
        endcase
    end

    assign w_accept = i_req.valid && w_in_ready;
    assign w_add_ok = (ALL_IDS || (32'(i_req.task_id) < TASKS)) && (i_req.period != '0);

    assign w_cursor_nxt = (r_cursor == SW'(SLOTS - 1)) ? '0 : (r_cursor + 1'b1);
    // A tick compares against the advanced cursor; an add arms from the current one.
    assign w_cursor_bus = w_cmd.tick ? w_cursor_nxt : r_cursor;

    // Token chain status: the head of the chain is cell 0.
    always_comb begin
        for (int k = 0; k < TASKS; k++) begin
            w_flags[k] = w_tok[k].flag;
        end
    end
    assign w_any_flag = |w_flags;
    assign w_rest_any = |(w_flags >> 1);
    assign w_can_out  = !r_out_valid || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_tick) begin
                    n_state = ST_DRAIN;
                end else if (w_accept && w_is_add && w_add_ok) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (w_drain_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        w_in_ready   = 1'b0;
        w_div_start  = 1'b0;
        w_shift      = 1'b0;
        w_emit       = 1'b0;
        w_emit_last  = 1'b0;
        w_drain_done = 1'b0;
        w_cmd        = '0;
        w_cmd.id     = i_req.task_id;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready  = 1'b1;
                w_cmd.tick  = w_accept && w_is_tick;
                w_cmd.del   = w_accept && w_is_del;
                w_div_start = w_accept && w_is_add && w_add_ok;
            end
            ST_DIV: begin
                w_cmd.arm = w_div_done;
                w_cmd.id  = r_arm_id;
            end
            ST_DRAIN: begin
                if (w_can_out) begin
                    w_shift     = 1'b1;
                    w_emit      = w_tok[0].flag;
                    // The sixteenth expiry closes the report even if more follow.
                    w_emit_last = w_emit &&
                                  (!w_rest_any || (r_cnt == CNT_W'(MAX_RESULTS - 1)));
                    w_drain_done = !w_any_flag || w_emit_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.tick) begin
                r_cursor <= w_cursor_nxt;
                r_cnt    <= '0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_arm_id <= i_req.task_id;
        end
        if (w_emit) begin
            r_out_id   <= w_tok[0].id;
            r_out_last <= w_emit_last;
        end
    end

    ptw_div #(
        .SLOTS (SLOTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.period),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        t_token w_next;
        if (g == TASKS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_tok[g+1];
        end

        ptw_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_cursor (w_cursor_bus),
            .i_rem    (w_div_rem),
            .i_quo    (RW'(w_div_quo)),
            .i_shift  (w_shift),
            .i_next   (w_next),
            .o_tok    (w_tok[g])
        );
    end

    assign i_req.ready      = w_in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.expired_id = r_out_id;
    assign o_rsp.last       = r_out_last;

endmodule

### design/ptw_chk.sv
// Checker: port-level assertions on the timing wheel, bound to the top level.
`timescale 1ns / 1ps

module ptw_chk import ptw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [MODE_W-1:0] i_in_mode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ID_W-1:0]   i_out_id,
    input logic              i_out_last
);

    // Reset leaves no expiry pending and the request side open.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("expiry pending or request side closed after reset");

    // A tick request always closes the request side once it is taken.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_mode == MODE_TICK) |=> !i_in_ready)
        else $error("request taken right after a tick");

    // Add and delete requests never produce an expiry.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_mode == MODE_ADD || i_in_mode == MODE_DEL)
         && !i_out_valid) |=> !i_out_valid)
        else $error("expiry after an add or delete request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_id) && $stable(i_out_last)))
        else $error("stalled expiry changed");

endmodule

bind periodic_timing_wheel ptw_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_mode   (i_req.mode),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_id    (o_rsp.expired_id),
    .i_out_last  (o_rsp.last)
);
